FILE: hw/rtl/psie_pkg.sv
// Shared types, constants and decode helpers for the Power-style integer subset executor.
// Used by the executor unit, psie_gpr and psie_exec; depends on nothing else.
package psie_pkg;

    localparam int unsigned MEM_WORDS_DEFAULT = 128;

    localparam int unsigned XLEN    = 64;
    localparam int unsigned NUM_GPR = 32;
    localparam int unsigned GPR_AW  = 5;
    localparam int unsigned PC_W    = 16;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned LADDR_W = 7;

    // Command codes.
    localparam logic CMD_EXEC    = 1'b0;
    localparam logic CMD_PRELOAD = 1'b1;

    // Primary opcodes.
    localparam logic [5:0] OP_X31  = 6'd31;
    localparam logic [5:0] OP_ADDI = 6'd14;
    localparam logic [5:0] OP_BEQ  = 6'd19;
    localparam logic [5:0] OP_LD   = 6'd58;
    localparam logic [5:0] OP_STD  = 6'd62;

    // Extended opcodes: ten-bit X form and nine-bit XO form.
    localparam logic [9:0] XO_NAND = 10'd476;
    localparam logic [9:0] XO_OR   = 10'd444;
    localparam logic [9:0] XO_AND  = 10'd28;
    localparam logic [9:0] XO_XOR  = 10'd316;
    localparam logic [8:0] XO_ADD  = 9'd266;
    localparam logic [8:0] XO_SUBF = 9'd40;

    typedef struct packed {
        logic              cmd;
        logic [31:0]       instr_word;
        logic [LADDR_W-1:0] load_addr;
        logic [WORD_W-1:0] load_data;
    } psie_in_t;

    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic              reg_written;
        logic [GPR_AW-1:0] dest_reg;
        logic [XLEN-1:0]   dest_value;
        logic              branch_taken;
        logic              mem_fault;
    } psie_out_t;

    // Execute stage result. For a load, value is replaced by the memory pair,
    // and swap tells that the low word sits in the odd bank.
    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic              reg_written;
        logic [GPR_AW-1:0] dest_reg;
        logic [XLEN-1:0]   value;
        logic              branch_taken;
        logic              mem_fault;
        logic              is_load;
        logic              swap;
    } psie_res_t;

    // Write enables for the even and odd data banks.
    typedef struct packed {
        logic we_even;
        logic we_odd;
    } psie_mem_ctl_t;

    // One register file write, also used to describe a pending write for forwarding.
    typedef struct packed {
        logic              en;
        logic [GPR_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } psie_gpr_wr_t;

    function automatic logic is_logic_op(input logic [31:0] w);
        logic [9:0] xo10;
        xo10 = w[10:1];
        return (w[31:26] == OP_X31) &&
               (xo10 == XO_NAND || xo10 == XO_OR || xo10 == XO_AND || xo10 == XO_XOR);
    endfunction

    // Port 0 carries RS for the logic ops and RA for everything else.
    function automatic logic [GPR_AW-1:0] gpr_port0_addr(input logic [31:0] w);
        return is_logic_op(w) ? w[25:21] : w[20:16];
    endfunction

    // Port 1 carries RB for opcode 31 and RT/RS for everything else.
    function automatic logic [GPR_AW-1:0] gpr_port1_addr(input logic [31:0] w);
        return (w[31:26] == OP_X31) ? w[15:11] : w[25:21];
    endfunction

endpackage

FILE: hw/rtl/power_subset_instruction_executor_unit.sv
// An accepted beat is registered in stage A, then moves into the stage B result register,
// from which its result beat is taken; a stall on the result holds it in stage B.
// Throughput: one beat per cycle while the result is not stalled, back to back, including dependent instructions.
// After reset the data memory is cleared, one even/odd pair per cycle, over all
// (MEM_WORDS + 1) / 2 bank entries (64 at the default size); item_stall is high until then.
// Reset clears the registers and the program counter; the register file reads as zero.
module power_subset_instruction_executor_unit #(
    parameter int unsigned MEM_WORDS = psie_pkg::MEM_WORDS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  psie_pkg::psie_in_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output psie_pkg::psie_out_t  result
);
    import psie_pkg::*;

    // The data memory is split into an even and an odd bank so that the two
    // words of a doubleword load or store are reached in the same cycle.
    localparam int unsigned BANK_DEPTH = (MEM_WORDS + 1) / 2;
    localparam int unsigned BANK_AW    = $clog2(BANK_DEPTH);
    localparam logic [BANK_AW-1:0] CLR_LAST = BANK_AW'(BANK_DEPTH - 1);

    // Pipeline control.
    logic a_valid_reg;
    logic a_valid_next;
    logic b_valid_reg;
    logic b_valid_next;
    logic accept;
    logic b_adv;
    logic a_move;
    logic out_acc;

    // Stage A holds the accepted beat while the register file read completes.
    psie_in_t a_item_reg;

    // Stage B is the result register seen at the output.
    psie_res_t b_res_reg;
    psie_res_t exec_res;

    logic [PC_W-1:0] pc_reg;

    // Memory clearing after reset.
    logic               clr_busy_reg;
    logic [BANK_AW-1:0] clr_idx_reg;

    // Register file.
    psie_gpr_wr_t    gpr_wr;
    psie_gpr_wr_t    gpr_fwd;
    logic [XLEN-1:0] op0;
    logic [XLEN-1:0] op1;

    // Data banks.
    psie_mem_ctl_t      mem_ctl;
    logic [BANK_AW-1:0] exec_addr_even;
    logic [BANK_AW-1:0] exec_addr_odd;
    logic [WORD_W-1:0]  exec_wdata_even;
    logic [WORD_W-1:0]  exec_wdata_odd;
    logic               even_we;
    logic               odd_we;
    logic [BANK_AW-1:0] even_waddr;
    logic [BANK_AW-1:0] odd_waddr;
    logic [WORD_W-1:0]  even_wdata;
    logic [WORD_W-1:0]  odd_wdata;
    logic [WORD_W-1:0]  even_q;
    logic [WORD_W-1:0]  odd_q;
    logic [WORD_W-1:0]  ld_lo;
    logic [WORD_W-1:0]  ld_hi;
    logic [XLEN-1:0]    b_value;

    // Stage B advances when it is empty or its beat is taken; stage A moves into B
    // whenever A holds a beat and B advances. A new beat enters A as A empties or moves.
    assign b_adv      = !b_valid_reg || !result_stall;
    assign a_move     = a_valid_reg && b_adv;
    assign out_acc    = b_valid_reg && !result_stall;
    assign item_stall = clr_busy_reg || (a_valid_reg && !b_adv);
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_move)
        begin
            a_valid_next = 1'b0;
        end

        b_valid_next = b_valid_reg;
        if (a_move)
        begin
            b_valid_next = 1'b1;
        end
        else if (out_acc)
        begin
            b_valid_next = 1'b0;
        end
    end

    // A load's value comes from the bank outputs, which were read as the beat
    // entered stage B and hold while the beat waits.
    assign ld_lo   = b_res_reg.swap ? odd_q : even_q;
    assign ld_hi   = b_res_reg.swap ? even_q : odd_q;
    assign b_value = b_res_reg.is_load ? {ld_hi, ld_lo} : b_res_reg.value;

    // The register file is written as the result beat leaves. Until then the
    // same write is forwarded to the beat in stage A.
    always_comb
    begin
        gpr_wr.en    = out_acc && b_res_reg.reg_written;
        gpr_wr.addr  = b_res_reg.dest_reg;
        gpr_wr.data  = b_value;
        gpr_fwd.en   = b_valid_reg && b_res_reg.reg_written;
        gpr_fwd.addr = b_res_reg.dest_reg;
        gpr_fwd.data = b_value;
    end

    psie_gpr u_gpr (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr0 (gpr_port0_addr(item.instr_word)),
        .rd_addr1 (gpr_port1_addr(item.instr_word)),
        .wr       (gpr_wr),
        .fwd      (gpr_fwd),
        .op0      (op0),
        .op1      (op1)
    );

    psie_exec #(.MEM_WORDS(MEM_WORDS)) u_exec (
        .item       (a_item_reg),
        .pc         (pc_reg),
        .op0        (op0),
        .op1        (op1),
        .res        (exec_res),
        .mem_ctl    (mem_ctl),
        .addr_even  (exec_addr_even),
        .addr_odd   (exec_addr_odd),
        .wdata_even (exec_wdata_even),
        .wdata_odd  (exec_wdata_odd)
    );

    // Stores and preloads write as their beat moves into stage B; the clearing
    // pass owns both write ports until it finishes.
    always_comb
    begin
        if (clr_busy_reg)
        begin
            even_we    = 1'b1;
            odd_we     = 1'b1;
            even_waddr = clr_idx_reg;
            odd_waddr  = clr_idx_reg;
            even_wdata = '0;
            odd_wdata  = '0;
        end
        else
        begin
            even_we    = a_move && mem_ctl.we_even;
            odd_we     = a_move && mem_ctl.we_odd;
            even_waddr = exec_addr_even;
            odd_waddr  = exec_addr_odd;
            even_wdata = exec_wdata_even;
            odd_wdata  = exec_wdata_odd;
        end
    end

    psie_ram #(.WIDTH(WORD_W), .DEPTH(BANK_DEPTH)) u_bank_even (
        .clk   (clk),
        .we    (even_we),
        .waddr (even_waddr),
        .wdata (even_wdata),
        .re    (a_move),
        .raddr (exec_addr_even),
        .rdata (even_q)
    );

    psie_ram #(.WIDTH(WORD_W), .DEPTH(BANK_DEPTH)) u_bank_odd (
        .clk   (clk),
        .we    (odd_we),
        .waddr (odd_waddr),
        .wdata (odd_wdata),
        .re    (a_move),
        .raddr (exec_addr_odd),
        .rdata (odd_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            pc_reg       <= '0;
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            if (a_move)
            begin
                pc_reg <= exec_res.next_pc;
            end
            if (clr_busy_reg)
            begin
                clr_idx_reg <= clr_idx_reg + BANK_AW'(1);
                if (clr_idx_reg == CLR_LAST)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_item_reg <= item;
        end
        if (a_move)
        begin
            b_res_reg <= exec_res;
        end
    end

    assign result_valid = b_valid_reg;

    always_comb
    begin
        result.next_pc      = b_res_reg.next_pc;
        result.reg_written  = b_res_reg.reg_written;
        result.dest_reg     = b_res_reg.dest_reg;
        result.dest_value   = b_value;
        result.branch_taken = b_res_reg.branch_taken;
        result.mem_fault    = b_res_reg.mem_fault;
    end

endmodule

FILE: hw/rtl/psie_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the register file copies and the data memory banks.
module psie_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/psie_gpr.sv
// General register file: two RAM copies for two read ports, valid bits for reset,
// a same-edge write bypass and forwarding of the pending write. Depends on psie_pkg, psie_ram.
module psie_gpr (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [psie_pkg::GPR_AW-1:0]    rd_addr0,
    input  logic [psie_pkg::GPR_AW-1:0]    rd_addr1,
    input  psie_pkg::psie_gpr_wr_t         wr,
    input  psie_pkg::psie_gpr_wr_t         fwd,
    output logic [psie_pkg::XLEN-1:0]      op0,
    output logic [psie_pkg::XLEN-1:0]      op1
);
    import psie_pkg::*;

    logic [NUM_GPR-1:0] valid_reg;
    logic               ovr0_reg;
    logic               ovr1_reg;
    logic               ovr0_next;
    logic               ovr1_next;
    logic [GPR_AW-1:0]  raddr0_reg;
    logic [GPR_AW-1:0]  raddr1_reg;
    logic [XLEN-1:0]    ovr_val0_reg;
    logic [XLEN-1:0]    ovr_val1_reg;
    logic [XLEN-1:0]    ovr_val0_next;
    logic [XLEN-1:0]    ovr_val1_next;
    logic [XLEN-1:0]    q0;
    logic [XLEN-1:0]    q1;
    logic               hit0;
    logic               hit1;

    psie_ram #(.WIDTH(XLEN), .DEPTH(NUM_GPR)) u_copy0 (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (rd_addr0),
        .rdata (q0)
    );

    psie_ram #(.WIDTH(XLEN), .DEPTH(NUM_GPR)) u_copy1 (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (rd_addr1),
        .rdata (q1)
    );

    // A read that meets a write on the same edge, or a register never written
    // since reset, takes its value from the override register instead of the RAM.
    always_comb
    begin
        hit0          = wr.en && (wr.addr == rd_addr0);
        hit1          = wr.en && (wr.addr == rd_addr1);
        ovr0_next     = hit0 || !valid_reg[rd_addr0];
        ovr1_next     = hit1 || !valid_reg[rd_addr1];
        ovr_val0_next = hit0 ? wr.data : '0;
        ovr_val1_next = hit1 ? wr.data : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ovr0_reg  <= 1'b0;
            ovr1_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                ovr0_reg <= ovr0_next;
                ovr1_reg <= ovr1_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            raddr0_reg   <= rd_addr0;
            raddr1_reg   <= rd_addr1;
            ovr_val0_reg <= ovr_val0_next;
            ovr_val1_reg <= ovr_val1_next;
        end
    end

    // The pending write of the older beat wins over everything captured at read time.
    always_comb
    begin
        if (fwd.en && (fwd.addr == raddr0_reg))
        begin
            op0 = fwd.data;
        end
        else if (ovr0_reg)
        begin
            op0 = ovr_val0_reg;
        end
        else
        begin
            op0 = q0;
        end

        if (fwd.en && (fwd.addr == raddr1_reg))
        begin
            op1 = fwd.data;
        end
        else if (ovr1_reg)
        begin
            op1 = ovr_val1_reg;
        end
        else
        begin
            op1 = q1;
        end
    end

endmodule

FILE: hw/rtl/psie_exec.sv
// Execute logic: decodes one beat, computes the register result, branch target,
// effective address, fault and data bank requests. Depends on psie_pkg.
module psie_exec #(
    parameter int unsigned MEM_WORDS = psie_pkg::MEM_WORDS_DEFAULT,
    localparam int unsigned BANK_AW = $clog2((MEM_WORDS + 1) / 2)
) (
    input  psie_pkg::psie_in_t             item,
    input  logic [psie_pkg::PC_W-1:0]      pc,
    input  logic [psie_pkg::XLEN-1:0]      op0,
    input  logic [psie_pkg::XLEN-1:0]      op1,
    output psie_pkg::psie_res_t            res,
    output psie_pkg::psie_mem_ctl_t        mem_ctl,
    output logic [BANK_AW-1:0]             addr_even,
    output logic [BANK_AW-1:0]             addr_odd,
    output logic [psie_pkg::WORD_W-1:0]    wdata_even,
    output logic [psie_pkg::WORD_W-1:0]    wdata_odd
);
    import psie_pkg::*;

    localparam int unsigned IDX_W    = BANK_AW + 1;
    localparam logic [XLEN-1:0] EA_LIMIT = XLEN'(MEM_WORDS - 1);
    localparam logic [31:0]     PRE_LIMIT = 32'(MEM_WORDS);

    logic [31:0]       w;
    logic [5:0]        po;
    logic [XLEN-1:0]   d14;
    logic [XLEN-1:0]   d16;
    logic [XLEN-1:0]   ea;
    logic              pair_ok;
    logic              pre_ok;
    logic [IDX_W-1:0]  ea_idx;
    logic [IDX_W-1:0]  ea_idx1;
    logic [IDX_W-1:0]  pre_idx;
    logic [PC_W-1:0]   disp;

    always_comb
    begin
        w       = item.instr_word;
        po      = w[31:26];
        d14     = {{(XLEN-14){w[15]}}, w[15:2]};
        d16     = {{(XLEN-16){w[15]}}, w[15:0]};
        ea      = op0 + d14;
        pair_ok = ea < EA_LIMIT;
        pre_ok  = 32'(item.load_addr) < PRE_LIMIT;
        ea_idx  = IDX_W'(ea);
        ea_idx1 = ea_idx + IDX_W'(1);
        pre_idx = IDX_W'(item.load_addr);

        res     = '0;
        mem_ctl = '0;
        disp    = PC_W'(1);

        if (item.cmd == CMD_PRELOAD)
        begin
            disp = '0;
            if (pre_ok)
            begin
                mem_ctl.we_even = !pre_idx[0];
                mem_ctl.we_odd  = pre_idx[0];
            end
            else
            begin
                res.mem_fault = 1'b1;
            end
        end
        else
        begin
            case (po)
                OP_X31:
                begin
                    if (is_logic_op(w))
                    begin
                        res.reg_written = 1'b1;
                        res.dest_reg    = w[20:16];
                        case (w[10:1])
                            XO_NAND: res.value = ~(op0 & op1);
                            XO_OR:   res.value = op0 | op1;
                            XO_AND:  res.value = op0 & op1;
                            default: res.value = op0 ^ op1;
                        endcase
                    end
                    else if (!w[10] && !w[0] && w[9:1] == XO_ADD)
                    begin
                        res.reg_written = 1'b1;
                        res.dest_reg    = w[25:21];
                        res.value       = op0 + op1;
                    end
                    else if (!w[10] && !w[0] && w[9:1] == XO_SUBF)
                    begin
                        res.reg_written = 1'b1;
                        res.dest_reg    = w[25:21];
                        res.value       = op1 - op0;
                    end
                end
                OP_ADDI:
                begin
                    res.reg_written = 1'b1;
                    res.dest_reg    = w[25:21];
                    res.value       = op0 + d16;
                end
                OP_BEQ:
                begin
                    if (w[1:0] == 2'b00 && op0 == op1)
                    begin
                        res.branch_taken = 1'b1;
                        disp             = PC_W'(d14);
                    end
                end
                OP_LD, OP_STD:
                begin
                    if (w[1:0] == 2'b00)
                    begin
                        if (!pair_ok)
                        begin
                            res.mem_fault = 1'b1;
                        end
                        else if (po == OP_LD)
                        begin
                            res.reg_written = 1'b1;
                            res.dest_reg    = w[25:21];
                            res.is_load     = 1'b1;
                        end
                        else
                        begin
                            // A word pair always covers one even and one odd entry.
                            mem_ctl.we_even = 1'b1;
                            mem_ctl.we_odd  = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        res.swap    = ea_idx[0];
        res.next_pc = pc + disp;

        if (item.cmd == CMD_PRELOAD)
        begin
            addr_even  = pre_idx[IDX_W-1:1];
            addr_odd   = pre_idx[IDX_W-1:1];
            wdata_even = item.load_data;
            wdata_odd  = item.load_data;
        end
        else
        begin
            addr_odd   = ea_idx[IDX_W-1:1];
            addr_even  = ea_idx[0] ? ea_idx1[IDX_W-1:1] : ea_idx[IDX_W-1:1];
            wdata_even = ea_idx[0] ? op1[63:32] : op1[31:0];
            wdata_odd  = ea_idx[0] ? op1[31:0] : op1[63:32];
        end
    end

endmodule
